>>> hdl/nnis_pkg.sv
// shared types and constants of the nearest neighbor image scaler
package nnis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COORD_W = 8;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int DIM_W   = 9;
    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = X_W + Y_W;
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // coordinate times clamped dimension stays below 2^(COORD_W + log2(MAX_DIM))
    localparam int DIVD_W  = COORD_W + $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(DIVD_W);
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 5 * COORD_W;
    localparam int OUT_DATA_W = PIX_W;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    typedef logic [X_W-1:0]   t_x;
    typedef logic [Y_W-1:0]   t_y;
    typedef logic [DIM_W-1:0] t_dim;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_C_START,
        S_DIV_C,
        S_DIV_R_START,
        S_DIV_R,
        S_READ,
        S_RESP
    } t_state;

endpackage

>>> hdl/nearest_neighbor_image_scaler_core.sv
// nearest neighbor image scaler: frame store plus coordinate scaling on one shared divider
// write transaction: stored in the cycle it is taken; the input stays ready after an in-range write
// out-of-range transaction: error result valid in the cycle after it is taken
// in-range read: result valid after two 16-step divisions, column then row, on the one
// radix-2 divider (start state, then done pulse), then a store read and the result load
// reset (synchronous, active low) sets all four dimensions to 256; store contents undefined
module nearest_neighbor_image_scaler_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // col[7:0], row[15:8], red_in[23:16], green_in[31:24], blue_in[39:32]
    input  logic [nnis_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [nnis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // range_error[0]
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nnis_pkg::DIM_W-1:0]      i_cfg_data
);
    import nnis_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam int PROD_W = COORD_W + DIM_W;

    t_dim r_src_w, r_src_h, r_dst_w, r_dst_h;
    t_state r_state, n_state;

    logic [PIX_W-1:0]  r_frame_mem [DEPTH];
    logic [PIX_W-1:0]  r_mem_q;
    logic [DIVD_W-1:0] r_prod;
    logic [COORD_W-1:0] r_row;
    t_x                r_sc;
    t_y                r_sr;
    logic              r_out_valid;
    logic              r_out_err;
    logic [PIX_W-1:0]  r_out_pix;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [COORD_W-1:0] w_col, w_row;
    logic [PIX_W-1:0]   w_pix_in;
    t_dim               w_sw, w_sh;
    logic               w_accept, w_wr_err, w_rd_err, w_in_err;
    logic               w_mem_we, w_mem_re;
    logic [COORD_W+DIM_W-1:0] w_col_prod, w_row_prod;

    assign w_col    = s_axis_tdata[COORD_W-1:0];
    assign w_row    = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_pix_in = {s_axis_tdata[3*COORD_W-1:2*COORD_W],
                       s_axis_tdata[4*COORD_W-1:3*COORD_W],
                       s_axis_tdata[5*COORD_W-1:4*COORD_W]};

    // source dimensions above the store act as the store size
    assign w_sw = (r_src_w > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : r_src_w;
    assign w_sh = (r_src_h > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_src_h;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_wr_err = ({1'b0, w_col} >= w_sw) || ({1'b0, w_row} >= w_sh);
    assign w_rd_err = ({1'b0, w_col} >= r_dst_w) || ({1'b0, w_row} >= r_dst_h)
                      || (w_sw == '0) || (w_sh == '0);
    assign w_in_err = (s_axis_tuser == FUNC_WRITE) ? w_wr_err : w_rd_err;

    assign w_col_prod = PROD_W'(w_col) * PROD_W'(w_sw);
    assign w_row_prod = PROD_W'(r_row) * PROD_W'(w_sh);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_RESET;
            r_src_h <= DIM_RESET;
            r_dst_w <= DIM_RESET;
            r_dst_h <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && s_axis_tuser == FUNC_READ && !w_rd_err) begin
                    n_state = S_DIV_C_START;
                end
            end
            S_DIV_C_START: n_state = S_DIV_C;
            S_DIV_C: begin
                if (w_div_rsp.done) begin
                    n_state = S_DIV_R_START;
                end
            end
            S_DIV_R_START: n_state = S_DIV_R;
            S_DIV_R: begin
                if (w_div_rsp.done) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready      = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod;
        w_div_req.divisor  = r_dst_w;
        w_mem_re           = 1'b0;
        unique case (r_state)
            S_IDLE:        s_axis_tready = !r_out_valid;
            S_DIV_C_START: w_div_req.start = 1'b1;
            S_DIV_R_START: begin
                w_div_req.start   = 1'b1;
                w_div_req.divisor = r_dst_h;
            end
            S_DIV_R:       w_div_req.divisor = r_dst_h;
            S_READ:        w_mem_re = 1'b1;
            default: ;
        endcase
    end

    assign w_mem_we = w_accept && (s_axis_tuser == FUNC_WRITE) && !w_wr_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod <= w_col_prod[DIVD_W-1:0];
            r_row  <= w_row;
        end else if (r_state == S_DIV_C && w_div_rsp.done) begin
            r_prod <= w_row_prod[DIVD_W-1:0];
            r_sc   <= t_x'(w_div_rsp.quotient);
        end
        if (r_state == S_DIV_R && w_div_rsp.done) begin
            r_sr <= t_y'(w_div_rsp.quotient);
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_frame_mem[{t_y'(w_row), t_x'(w_col)}] <= w_pix_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_mem_q <= r_frame_mem[{r_sr, r_sc}];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_in_err) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_RESP) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_err) begin
            r_out_err <= 1'b1;
            r_out_pix <= '0;
        end else if (r_state == S_RESP) begin
            r_out_err <= 1'b0;
            r_out_pix <= r_mem_q;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tdata  = {r_out_pix[CH_W-1:0],
                            r_out_pix[2*CH_W-1:CH_W],
                            r_out_pix[3*CH_W-1:2*CH_W]};

    nnis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    a_no_accept_with_pending_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_error_colors_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("range error result carries color");

    a_div_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_C || r_state == S_DIV_R))
        else $error("divider finished outside a wait state");

    a_read_starts_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == FUNC_READ && !w_rd_err) |=>
        (r_state == S_DIV_C_START))
        else $error("in-range read did not start the column division");

endmodule

>>> hdl/nnis_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module nnis_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nnis_pkg::t_div_req i_req,
    output nnis_pkg::t_div_rsp o_rsp
);
    import nnis_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_div;

    logic [DIM_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DIM_W:0]    w_diff;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIVD_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_diff   = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits DIM_W bits either way
            r_rem <= w_ge ? w_diff[DIM_W-1:0] : w_rem_sh[DIM_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> dv/tb_nearest_neighbor_image_scaler_core.sv
// testbench for the nearest neighbor image scaler core: frame store writes and scaled reads
`timescale 1ns / 100ps

module tb_nearest_neighbor_image_scaler_core;
    import nnis_pkg::*;

    localparam int ITEMS_TARGET   = 1550;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic            func;
        t_x              col;
        t_y              row;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel_op;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            range_err;
    } t_pixel_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_SRC_WIDTH;
    logic [DIM_W-1:0]      i_cfg_data = '0;

    nearest_neighbor_image_scaler_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // scaler state as the testbench sees it
    t_dim                 cfg_src_w = DIM_RESET;
    t_dim                 cfg_src_h = DIM_RESET;
    t_dim                 cfg_dst_w = DIM_RESET;
    t_dim                 cfg_dst_h = DIM_RESET;
    logic [PIX_W-1:0]     frame_shadow [MAX_WIDTH*MAX_HEIGHT];
    // source pixels that some queued write will have filled
    bit                   written_map [MAX_WIDTH*MAX_HEIGHT];

    t_pixel_op            pixel_ops_q [$];
    t_pixel_result        expected_pixels_q [$];
    t_pixel_op            cur_op;
    t_pixel_result        want;
    int                   n_items = 0;
    int                   n_errors = 0;
    bit                   no_idle = 1'b0;
    int                   gap_left = 0;
    int                   burst_left = 8;
    int                   rx_left = 0;
    bit                   rx_on = 1'b1;
    int                   quiet_cycles = 0;

    function automatic int eff_dim(input t_dim d, input int lim);
        return (d > lim) ? lim : int'(d);
    endfunction

    // destination coordinate to source coordinate; 0 when the read is out of range
    function automatic bit scale_to_source(input int col, input int row,
                                           output int sc, output int sr);
        int sw;
        int sh;
        sw = eff_dim(cfg_src_w, MAX_WIDTH);
        sh = eff_dim(cfg_src_h, MAX_HEIGHT);
        sc = 0;
        sr = 0;
        if (col >= int'(cfg_dst_w) || row >= int'(cfg_dst_h) || sw == 0 || sh == 0)
            return 1'b0;
        sc = (col * sw) / int'(cfg_dst_w);
        sr = (row * sh) / int'(cfg_dst_h);
        return 1'b1;
    endfunction

    function automatic void predict_scaled_pixel(input t_pixel_op op);
        t_pixel_result res;
        int sc;
        int sr;
        res = '0;
        res.range_err = 1'b1;
        if (op.func == FUNC_WRITE) begin
            if (int'(op.col) < eff_dim(cfg_src_w, MAX_WIDTH) &&
                int'(op.row) < eff_dim(cfg_src_h, MAX_HEIGHT)) begin
                frame_shadow[int'(op.row) * MAX_WIDTH + int'(op.col)] =
                    {op.red, op.green, op.blue};
                return;
            end
        end else if (scale_to_source(int'(op.col), int'(op.row), sc, sr)) begin
            {res.red, res.green, res.blue} = frame_shadow[sr * MAX_WIDTH + sc];
            res.range_err = 1'b0;
        end
        expected_pixels_q.push_back(res);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        return PIX_W'($urandom);
    endfunction

    task automatic push_op(input logic func, input int col, input int row,
                           input logic [PIX_W-1:0] rgb);
        t_pixel_op op;
        op.func = func;
        op.col = t_x'(col);
        op.row = t_y'(row);
        {op.red, op.green, op.blue} = rgb;
        if (func == FUNC_WRITE && col < eff_dim(cfg_src_w, MAX_WIDTH) &&
            row < eff_dim(cfg_src_h, MAX_HEIGHT))
            written_map[row * MAX_WIDTH + col] = 1'b1;
        pixel_ops_q.push_back(op);
        n_items++;
    endtask

    // fill the source pixel first when the read would land on an empty entry
    task automatic push_read(input int col, input int row);
        int sc;
        int sr;
        if (scale_to_source(col, row, sc, sr) && !written_map[sr * MAX_WIDTH + sc])
            push_op(FUNC_WRITE, sc, sr, rand_pix());
        push_op(FUNC_READ, col, row, rand_pix());
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_ops_q.size() != 0 || s_axis_tvalid || expected_pixels_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_dim val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SRC_WIDTH:  cfg_src_w = val;
            REG_SRC_HEIGHT: cfg_src_h = val;
            REG_DST_WIDTH:  cfg_dst_w = val;
            REG_DST_HEIGHT: cfg_dst_h = val;
        endcase
    endtask

    task automatic set_dims(input int sw, input int sh, input int dw, input int dh);
        wait_idle();
        write_reg(REG_SRC_WIDTH, t_dim'(sw));
        write_reg(REG_SRC_HEIGHT, t_dim'(sh));
        write_reg(REG_DST_WIDTH, t_dim'(dw));
        write_reg(REG_DST_HEIGHT, t_dim'(dh));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_dim(input bit wide, input int hi);
        if (!wide)
            return $urandom_range(1, hi);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 511;
            2: return 257;
            3: return 256;
            4: return 1;
            default: return $urandom_range(2, 255);
        endcase
    endfunction

    // mostly inside the frame, with its last line and the first one past it favored
    function automatic int pick_coord(input int extent);
        int n;
        n = (extent > 256) ? 256 : extent;
        if (n == 0)
            return $urandom_range(0, 255);
        case ($urandom_range(0, 7))
            0: return n - 1;
            1: return (n < 256) ? n : 0;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    // input side: bursts of transactions separated by random gaps, or a steady stream in no-idle phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_scaled_pixel(cur_op);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_ops_q.size() > 0) begin
                    cur_op = pixel_ops_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_op.blue, cur_op.green, cur_op.red,
                                      cur_op.row, cur_op.col};
                    s_axis_tuser  <= cur_op.func;
                    if (!no_idle) begin
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = $urandom_range(1, 10);
                        end
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each result and, outside no-idle phases, stall on a pattern of its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels_q.size() == 0) begin
                    $error("result with nothing pending: tdata %h range_error %b",
                           m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end else begin
                    want = expected_pixels_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[15:8] !== want.green) begin
                        $error("green_out: expected %0d, got %0d",
                               want.green, m_axis_tdata[15:8]);
                        n_errors++;
                    end
                    if (m_axis_tdata[23:16] !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d",
                               want.blue, m_axis_tdata[23:16]);
                        n_errors++;
                    end
                    if (m_axis_tuser !== want.range_err) begin
                        $error("range_error: expected %0b, got %0b",
                               want.range_err, m_axis_tuser);
                        n_errors++;
                    end
                end
            end
            if (rx_left <= 0) begin
                if (no_idle || !rx_on) begin
                    rx_on   = 1'b1;
                    rx_left = $urandom_range(1, 30);
                end else begin
                    rx_on   = 1'b0;
                    rx_left = $urandom_range(1, 15);
                end
            end
            rx_left--;
            m_axis_tready <= rx_on;
        end
    end

    // ends the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  ph;
        int  k;
        int  n_ph;
        int  sel;
        bit  wide;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset dimensions: identity mapping, frame corners, darkest and brightest pixels
        push_op(FUNC_WRITE, 0, 0, 24'h000000);
        push_op(FUNC_WRITE, 255, 255, 24'hffffff);
        push_op(FUNC_WRITE, 255, 0, 24'h5a3c96);
        push_op(FUNC_WRITE, 0, 255, 24'ha5c369);
        push_read(0, 0);
        push_read(255, 255);
        push_read(255, 0);
        push_read(0, 255);
        // one-pixel source: every read lands on the origin, writes beyond it fail
        set_dims(1, 1, 256, 256);
        push_read(255, 255);
        push_op(FUNC_WRITE, 1, 0, rand_pix());
        push_op(FUNC_WRITE, 0, 1, rand_pix());
        // zero source dimensions
        set_dims(0, 0, 5, 5);
        push_read(0, 0);
        push_op(FUNC_WRITE, 0, 0, rand_pix());
        // source above the store clamps, widest destination
        set_dims(511, 300, 511, 511);
        push_read(255, 255);
        push_op(FUNC_WRITE, 255, 255, rand_pix());
        // zero destination dimensions
        set_dims(256, 256, 0, 0);
        push_read(0, 0);
        // uneven ratio with reads at and past the destination edge
        set_dims(3, 2, 7, 1);
        push_read(6, 0);
        push_read(7, 0);
        push_read(0, 1);

        ph = 0;
        while (n_items < ITEMS_TARGET) begin
            wide = ($urandom_range(0, 4) == 0);
            set_dims(pick_dim(wide, 16), pick_dim(wide, 16),
                     pick_dim(wide, 24), pick_dim(wide, 24));
            no_idle = ($urandom_range(0, 5) == 0);
            n_ph = $urandom_range(30, 100);
            for (k = 0; k < n_ph; k++) begin
                // hold the input side until every pending result is back
                if (k == n_ph / 2 && (ph == 0 || $urandom_range(0, 3) == 0))
                    wait_idle();
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    push_read(pick_coord(int'(cfg_dst_w)), pick_coord(int'(cfg_dst_h)));
                else if (sel < 75)
                    push_op(FUNC_WRITE, pick_coord(eff_dim(cfg_src_w, MAX_WIDTH)),
                            pick_coord(eff_dim(cfg_src_h, MAX_HEIGHT)), rand_pix());
                else if (sel < 88)
                    push_op(FUNC_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                            rand_pix());
                else
                    push_read($urandom_range(0, 255), $urandom_range(0, 255));
            end
            ph++;
        end

        wait_idle();
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/nnis_pkg.sv
hdl/nnis_div.sv
hdl/nearest_neighbor_image_scaler_core.sv
dv/tb_nearest_neighbor_image_scaler_core.sv
